// ===== rtl/core/nfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the next-fit free-list allocator.
// Depends on nothing; every other file refers to it by scoped names.
package nfa_pkg;

  localparam int MAX_REGIONS = 4;
  localparam int MAX_BLOCKS  = 16;
  localparam int ADDR_BITS   = 32;

  localparam int REG_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int MEM_W  = REG_W + BLK_W;
  localparam int MEM_D  = 1 << MEM_W;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t addr;
    addr_t size;
  } blk_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BELOW = 2'd3
  } stat_t;

endpackage

// ===== rtl/core/nfa_in_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with action, address and size.
// Depends on nfa_pkg.
interface nfa_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  nfa_pkg::addr_t        addr;
  nfa_pkg::addr_t        size;

  modport source(output valid, action, addr, size, input ready);
  modport sink(input valid, action, addr, size, output ready);
endinterface

// ===== rtl/core/nfa_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with result address and status.
// Depends on nfa_pkg.
interface nfa_out_if;
  logic                  valid;
  logic                  ready;
  nfa_pkg::addr_t        result_addr;
  logic [1:0]            status;

  modport source(output valid, result_addr, status, input ready);
  modport sink(input valid, result_addr, status, output ready);
endinterface

// ===== rtl/core/next_fit_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// Next-fit two-level free-list allocator with coalescing, top level.
// Depends on nfa_pkg, nfa_in_if and nfa_out_if.
//
//  channel | dir | word fields                  | handshake
//  in_ch   | in  | action, addr, size           | valid/ready
//  out_ch  | out | result_addr, status          | valid/ready
//
// One word at a time; each free-block entry visited or shifted is a read from
// the block memory (separate read and write ports) followed by a compare or a write.
// A region search steps through the regions in order of base address.
// Reset clears counts and cursors; no clearing pass over the memory.
// A waiting result holds in the output register; the next word is taken
// meanwhile, and the block stalls only when a second result is ready.
module next_fit_free_list_allocator_top (
  input  logic      clk,
  input  logic      rst_n,
  nfa_in_if.sink    in_ch,
  nfa_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_ASRCH, S_AINS, S_LREG, S_LRD, S_LCMP, S_LNEXT,
    S_DRD, S_DWR, S_RREG, S_RRD, S_RCMP, S_RDEC, S_RMRG, S_IRD, S_IWR,
    S_DONE
  } state_t;

  state_t st_r, st_nxt;

  nfa_pkg::addr_t a_r, a_nxt, s_r, s_nxt;
  nfa_pkg::addr_t res_r, res_nxt;
  logic [1:0]     stat_r, stat_nxt;

  logic [nfa_pkg::REG_W-1:0]  ord_r [nfa_pkg::MAX_REGIONS];
  logic [nfa_pkg::REG_W-1:0]  ord_nxt [nfa_pkg::MAX_REGIONS];
  nfa_pkg::addr_t             base_r [nfa_pkg::MAX_REGIONS];
  nfa_pkg::addr_t             base_nxt [nfa_pkg::MAX_REGIONS];
  logic [nfa_pkg::CNT_W-1:0]  fcnt_r [nfa_pkg::MAX_REGIONS];
  logic [nfa_pkg::CNT_W-1:0]  fcnt_nxt [nfa_pkg::MAX_REGIONS];
  logic [nfa_pkg::CNT_W-1:0]  fcur_r [nfa_pkg::MAX_REGIONS];
  logic [nfa_pkg::CNT_W-1:0]  fcur_nxt [nfa_pkg::MAX_REGIONS];
  logic [nfa_pkg::RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [nfa_pkg::REG_W-1:0]  rcur_r, rcur_nxt;

  logic [nfa_pkg::RCNT_W-1:0] i_r, i_nxt;
  logic [nfa_pkg::REG_W-1:0]  lr_r, lr_nxt;
  logic [nfa_pkg::REG_W-1:0]  ph_r, ph_nxt;
  logic [nfa_pkg::CNT_W-1:0]  n_r, n_nxt;
  logic [nfa_pkg::BLK_W-1:0]  k_r, k_nxt;
  logic [nfa_pkg::CNT_W-1:0]  v_r, v_nxt;
  logic [nfa_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [nfa_pkg::CNT_W-1:0]  j_r, j_nxt;
  nfa_pkg::blk_t              prev_r, prev_nxt, cur_r, cur_nxt;
  nfa_pkg::addr_t             sum_r, sum_nxt;

  logic           ov_r, ov_nxt;
  nfa_pkg::addr_t oaddr_r, oaddr_nxt;
  logic [1:0]     ostat_r, ostat_nxt;

  nfa_pkg::blk_t             mem [nfa_pkg::MEM_D];
  nfa_pkg::blk_t             rd_q;
  logic                      mem_we;
  logic [nfa_pkg::MEM_W-1:0] mem_wa, mem_ra;
  nfa_pkg::blk_t             mem_wd;

  logic [nfa_pkg::REG_W-1:0] ord_at_i;
  logic [nfa_pkg::REG_W-1:0] ins_ph;
  logic                      in_fire;

  assign in_ch.ready        = (st_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = ov_r;
  assign out_ch.result_addr = oaddr_r;
  assign out_ch.status      = ostat_r;
  assign ord_at_i           = ord_r[i_r[nfa_pkg::REG_W-1:0]];
  assign ins_ph             = rcnt_r[nfa_pkg::REG_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_comb begin
    st_nxt    = st_r;
    a_nxt     = a_r;
    s_nxt     = s_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    ord_nxt   = ord_r;
    base_nxt  = base_r;
    fcnt_nxt  = fcnt_r;
    fcur_nxt  = fcur_r;
    rcnt_nxt  = rcnt_r;
    rcur_nxt  = rcur_r;
    i_nxt     = i_r;
    lr_nxt    = lr_r;
    ph_nxt    = ph_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    pos_nxt   = pos_r;
    j_nxt     = j_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    sum_nxt   = sum_r;
    ov_nxt    = ov_r && !out_ch.ready;
    oaddr_nxt = oaddr_r;
    ostat_nxt = ostat_r;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_ra    = '0;

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          a_nxt    = in_ch.addr;
          s_nxt    = in_ch.size;
          res_nxt  = '0;
          stat_nxt = nfa_pkg::ST_OK;
          i_nxt    = '0;
          case (in_ch.action)
            nfa_pkg::ACT_ADD: begin
              if (rcnt_r == nfa_pkg::RCNT_W'(nfa_pkg::MAX_REGIONS)) begin
                stat_nxt = nfa_pkg::ST_FULL;
                st_nxt   = S_DONE;
              end else begin
                st_nxt = S_ASRCH;
              end
            end
            nfa_pkg::ACT_ALLOC: begin
              if (rcnt_r == '0) begin
                stat_nxt = nfa_pkg::ST_NOFIT;
                st_nxt   = S_DONE;
              end else begin
                lr_nxt = (nfa_pkg::RCNT_W'(rcur_r) < rcnt_r) ? rcur_r : '0;
                st_nxt = S_LREG;
              end
            end
            nfa_pkg::ACT_FREE: st_nxt = S_RREG;
            default:           st_nxt = S_DONE;
          endcase
        end
      end

      S_ASRCH: begin
        if (i_r < rcnt_r && base_r[ord_at_i] <= a_r) begin
          i_nxt = i_r + nfa_pkg::RCNT_W'(1);
        end else begin
          st_nxt = S_AINS;
        end
      end

      S_AINS: begin
        for (int e = 0; e < nfa_pkg::MAX_REGIONS; e++) begin
          if (nfa_pkg::RCNT_W'(e) > i_r) begin
            ord_nxt[e] = ord_r[(e > 0) ? e - 1 : 0];
          end else if (nfa_pkg::RCNT_W'(e) == i_r) begin
            ord_nxt[e] = ins_ph;
          end
        end
        base_nxt[ins_ph] = a_r;
        fcnt_nxt[ins_ph] = nfa_pkg::CNT_W'(1);
        fcur_nxt[ins_ph] = '0;
        mem_we           = 1'b1;
        mem_wa           = {ins_ph, nfa_pkg::BLK_W'(0)};
        mem_wd           = '{addr: a_r, size: s_r};
        rcnt_nxt         = rcnt_r + nfa_pkg::RCNT_W'(1);
        rcur_nxt         = i_r[nfa_pkg::REG_W-1:0];
        st_nxt           = S_DONE;
      end

      S_LREG: begin
        ph_nxt = ord_r[lr_r];
        n_nxt  = fcnt_r[ord_r[lr_r]];
        v_nxt  = '0;
        k_nxt  = (fcur_r[ord_r[lr_r]] < fcnt_r[ord_r[lr_r]]) ?
                 fcur_r[ord_r[lr_r]][nfa_pkg::BLK_W-1:0] : '0;
        st_nxt = (fcnt_r[ord_r[lr_r]] == '0) ? S_LNEXT : S_LRD;
      end

      S_LRD: begin
        mem_ra = {ph_r, k_r};
        st_nxt = S_LCMP;
      end

      S_LCMP: begin
        if (rd_q.size >= s_r) begin
          res_nxt        = rd_q.addr;
          fcur_nxt[ph_r] = nfa_pkg::CNT_W'(k_r);
          rcur_nxt       = lr_r;
          if (rd_q.size > s_r) begin
            mem_we = 1'b1;
            mem_wa = {ph_r, k_r};
            mem_wd = '{addr: rd_q.addr + s_r, size: rd_q.size - s_r};
            st_nxt = S_DONE;
          end else begin
            j_nxt  = nfa_pkg::CNT_W'(k_r);
            st_nxt = S_DRD;
          end
        end else if (v_r + nfa_pkg::CNT_W'(1) == n_r) begin
          st_nxt = S_LNEXT;
        end else begin
          v_nxt  = v_r + nfa_pkg::CNT_W'(1);
          k_nxt  = (nfa_pkg::CNT_W'(k_r) + nfa_pkg::CNT_W'(1) == n_r) ?
                   '0 : k_r + nfa_pkg::BLK_W'(1);
          st_nxt = S_LRD;
        end
      end

      S_LNEXT: begin
        if (i_r + nfa_pkg::RCNT_W'(1) == rcnt_r) begin
          stat_nxt = nfa_pkg::ST_NOFIT;
          res_nxt  = '0;
          st_nxt   = S_DONE;
        end else begin
          i_nxt  = i_r + nfa_pkg::RCNT_W'(1);
          lr_nxt = (nfa_pkg::RCNT_W'(lr_r) + nfa_pkg::RCNT_W'(1) == rcnt_r) ?
                   '0 : lr_r + nfa_pkg::REG_W'(1);
          st_nxt = S_LREG;
        end
      end

      S_DRD: begin
        if (j_r + nfa_pkg::CNT_W'(1) < fcnt_r[ph_r]) begin
          mem_ra = {ph_r, j_r[nfa_pkg::BLK_W-1:0] + nfa_pkg::BLK_W'(1)};
          st_nxt = S_DWR;
        end else begin
          fcnt_nxt[ph_r] = fcnt_r[ph_r] - nfa_pkg::CNT_W'(1);
          st_nxt         = S_DONE;
        end
      end

      S_DWR: begin
        mem_we = 1'b1;
        mem_wa = {ph_r, j_r[nfa_pkg::BLK_W-1:0]};
        mem_wd = rd_q;
        j_nxt  = j_r + nfa_pkg::CNT_W'(1);
        st_nxt = S_DRD;
      end

      S_RREG: begin
        if (i_r < rcnt_r && base_r[ord_at_i] <= a_r) begin
          i_nxt = i_r + nfa_pkg::RCNT_W'(1);
        end else if (i_r == '0) begin
          stat_nxt = nfa_pkg::ST_BELOW;
          st_nxt   = S_DONE;
        end else begin
          lr_nxt  = ord_r[i_r[nfa_pkg::REG_W-1:0] - nfa_pkg::REG_W'(1)];
          ph_nxt  = ord_r[i_r[nfa_pkg::REG_W-1:0] - nfa_pkg::REG_W'(1)];
          n_nxt   = fcnt_r[ord_r[i_r[nfa_pkg::REG_W-1:0] - nfa_pkg::REG_W'(1)]];
          pos_nxt = '0;
          st_nxt  = (fcnt_r[ord_r[i_r[nfa_pkg::REG_W-1:0] - nfa_pkg::REG_W'(1)]] == '0) ?
                    S_RDEC : S_RRD;
        end
      end

      S_RRD: begin
        mem_ra = {ph_r, pos_r[nfa_pkg::BLK_W-1:0]};
        st_nxt = S_RCMP;
      end

      S_RCMP: begin
        if (rd_q.addr <= a_r) begin
          prev_nxt = rd_q;
          pos_nxt  = pos_r + nfa_pkg::CNT_W'(1);
          st_nxt   = (pos_r + nfa_pkg::CNT_W'(1) == n_r) ? S_RDEC : S_RRD;
        end else begin
          cur_nxt = rd_q;
          st_nxt  = S_RDEC;
        end
      end

      S_RDEC: begin
        if (pos_r != '0 && prev_r.addr + prev_r.size == a_r) begin
          sum_nxt = prev_r.size + s_r;
          st_nxt  = S_RMRG;
        end else if (pos_r < n_r && cur_r.addr == a_r + s_r) begin
          mem_we = 1'b1;
          mem_wa = {ph_r, pos_r[nfa_pkg::BLK_W-1:0]};
          mem_wd = '{addr: a_r, size: cur_r.size + s_r};
          st_nxt = S_DONE;
        end else if (n_r >= nfa_pkg::CNT_W'(nfa_pkg::MAX_BLOCKS)) begin
          stat_nxt = nfa_pkg::ST_FULL;
          st_nxt   = S_DONE;
        end else begin
          j_nxt  = n_r;
          st_nxt = S_IRD;
        end
      end

      S_RMRG: begin
        mem_we = 1'b1;
        mem_wa = {ph_r, pos_r[nfa_pkg::BLK_W-1:0] - nfa_pkg::BLK_W'(1)};
        if (pos_r < n_r && cur_r.addr == prev_r.addr + sum_r) begin
          mem_wd         = '{addr: prev_r.addr, size: sum_r + cur_r.size};
          fcur_nxt[ph_r] = pos_r;
          j_nxt          = pos_r;
          st_nxt         = S_DRD;
        end else begin
          mem_wd = '{addr: prev_r.addr, size: sum_r};
          st_nxt = S_DONE;
        end
      end

      S_IRD: begin
        if (j_r > pos_r) begin
          mem_ra = {ph_r, j_r[nfa_pkg::BLK_W-1:0] - nfa_pkg::BLK_W'(1)};
          st_nxt = S_IWR;
        end else begin
          mem_we         = 1'b1;
          mem_wa         = {ph_r, pos_r[nfa_pkg::BLK_W-1:0]};
          mem_wd         = '{addr: a_r, size: s_r};
          fcnt_nxt[ph_r] = n_r + nfa_pkg::CNT_W'(1);
          fcur_nxt[ph_r] = pos_r;
          st_nxt         = S_DONE;
        end
      end

      S_IWR: begin
        mem_we = 1'b1;
        mem_wa = {ph_r, j_r[nfa_pkg::BLK_W-1:0]};
        mem_wd = rd_q;
        j_nxt  = j_r - nfa_pkg::CNT_W'(1);
        st_nxt = S_IRD;
      end

      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          oaddr_nxt = res_r;
          ostat_nxt = stat_r;
          st_nxt    = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      rcnt_r <= '0;
      rcur_r <= '0;
      ph_r   <= '0;
      for (int e = 0; e < nfa_pkg::MAX_REGIONS; e++) begin
        fcnt_r[e] <= '0;
        fcur_r[e] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      rcnt_r <= rcnt_nxt;
      rcur_r <= rcur_nxt;
      ph_r   <= ph_nxt;
      fcnt_r <= fcnt_nxt;
      fcur_r <= fcur_nxt;
    end
    a_r     <= a_nxt;
    s_r     <= s_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
    ord_r   <= ord_nxt;
    base_r  <= base_nxt;
    i_r     <= i_nxt;
    lr_r    <= lr_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    v_r     <= v_nxt;
    pos_r   <= pos_nxt;
    j_r     <= j_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    sum_r   <= sum_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= nfa_pkg::RCNT_W'(nfa_pkg::MAX_REGIONS))
    else $error("region count past table size");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("word taken while previous word in work");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r == S_DONE))
    else $error("result raised outside completion");

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r[ph_r] <= nfa_pkg::CNT_W'(nfa_pkg::MAX_BLOCKS))
    else $error("free count past list size");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the next-fit free-list allocator: directed table, then random words.
// A local predictor keeps its own heap and free-block lists and checks every result.
// Depends on nfa_pkg, nfa_in_if, nfa_out_if and next_fit_free_list_allocator_top.
module tb_top;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM = 530;

  typedef struct {
    logic [1:0]      action;
    nfa_pkg::addr_t  addr;
    nfa_pkg::addr_t  size;
    bit              typed;
    nfa_pkg::addr_t  exp_addr;
    nfa_pkg::stat_t  exp_stat;
  } word_t;

  typedef struct {
    nfa_pkg::addr_t addr;
    nfa_pkg::stat_t stat;
  } answer_t;

  typedef struct {
    nfa_pkg::addr_t addr;
    nfa_pkg::addr_t size;
  } span_t;

  logic clk;
  logic rst_n;
  nfa_in_if  in_ch();
  nfa_out_if out_ch();

  next_fit_free_list_allocator_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // allocator image
  nfa_pkg::addr_t heap_base[nfa_pkg::MAX_REGIONS];
  int             heap_cnt;
  int             heap_cur;
  nfa_pkg::addr_t blk_addr[nfa_pkg::MAX_REGIONS][nfa_pkg::MAX_BLOCKS];
  nfa_pkg::addr_t blk_size[nfa_pkg::MAX_REGIONS][nfa_pkg::MAX_BLOCKS];
  int             blk_cnt[nfa_pkg::MAX_REGIONS];
  int             blk_cur[nfa_pkg::MAX_REGIONS];

  answer_t pending[$];
  span_t   live[$];
  int      errs;
  int      idle;

  function automatic void drop_entry(int r, int k);
    for (int j = k; j + 1 < blk_cnt[r]; j++) begin
      blk_addr[r][j] = blk_addr[r][j+1];
      blk_size[r][j] = blk_size[r][j+1];
    end
    blk_cnt[r]--;
  endfunction

  function automatic bit carve(int r, nfa_pkg::addr_t sz, output nfa_pkg::addr_t got);
    int n;
    int start;
    int k;
    n = blk_cnt[r];
    start = (blk_cur[r] < n) ? blk_cur[r] : 0;
    got = '0;
    for (int v = 0; v < n; v++) begin
      k = start + v;
      if (k >= n) k -= n;
      if (blk_size[r][k] >= sz) begin
        got = blk_addr[r][k];
        if (blk_size[r][k] > sz) begin
          blk_addr[r][k] = blk_addr[r][k] + sz;
          blk_size[r][k] = blk_size[r][k] - sz;
        end else begin
          drop_entry(r, k);
        end
        blk_cur[r] = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic nfa_pkg::stat_t add_heap(nfa_pkg::addr_t a, nfa_pkg::addr_t s);
    int pos;
    if (heap_cnt >= nfa_pkg::MAX_REGIONS) return nfa_pkg::ST_FULL;
    pos = 0;
    while (pos < heap_cnt && heap_base[pos] <= a) pos++;
    for (int j = heap_cnt; j > pos; j--) begin
      heap_base[j] = heap_base[j-1];
      for (int b = 0; b < nfa_pkg::MAX_BLOCKS; b++) begin
        blk_addr[j][b] = blk_addr[j-1][b];
        blk_size[j][b] = blk_size[j-1][b];
      end
      blk_cnt[j] = blk_cnt[j-1];
      blk_cur[j] = blk_cur[j-1];
    end
    heap_base[pos] = a;
    blk_addr[pos][0] = a;
    blk_size[pos][0] = s;
    blk_cnt[pos] = 1;
    blk_cur[pos] = 0;
    heap_cnt++;
    heap_cur = pos;
    return nfa_pkg::ST_OK;
  endfunction

  function automatic nfa_pkg::stat_t give_back(nfa_pkg::addr_t a, nfa_pkg::addr_t s);
    int r;
    int pos;
    int n;
    int p;
    r = 0;
    while (r < heap_cnt && heap_base[r] <= a) r++;
    if (r == 0) return nfa_pkg::ST_BELOW;
    r--;
    n = blk_cnt[r];
    pos = 0;
    while (pos < n && blk_addr[r][pos] <= a) pos++;
    if (pos > 0) begin
      p = pos - 1;
      if (nfa_pkg::addr_t'(blk_addr[r][p] + blk_size[r][p]) == a) begin
        blk_size[r][p] = blk_size[r][p] + s;
        if (pos < n &&
            blk_addr[r][pos] == nfa_pkg::addr_t'(blk_addr[r][p] + blk_size[r][p])) begin
          blk_size[r][p] = blk_size[r][p] + blk_size[r][pos];
          drop_entry(r, pos);
          blk_cur[r] = pos;
        end
        return nfa_pkg::ST_OK;
      end
    end
    if (pos < n && blk_addr[r][pos] == nfa_pkg::addr_t'(a + s)) begin
      blk_size[r][pos] = blk_size[r][pos] + s;
      blk_addr[r][pos] = a;
      return nfa_pkg::ST_OK;
    end
    if (n >= nfa_pkg::MAX_BLOCKS) return nfa_pkg::ST_FULL;
    for (int j = n; j > pos; j--) begin
      blk_addr[r][j] = blk_addr[r][j-1];
      blk_size[r][j] = blk_size[r][j-1];
    end
    blk_addr[r][pos] = a;
    blk_size[r][pos] = s;
    blk_cnt[r] = n + 1;
    blk_cur[r] = pos;
    return nfa_pkg::ST_OK;
  endfunction

  function automatic answer_t allocator_step(logic [1:0] act, nfa_pkg::addr_t a,
                                             nfa_pkg::addr_t s);
    answer_t ans;
    int start;
    int r;
    bit ok;
    ans.addr = '0;
    ans.stat = nfa_pkg::ST_OK;
    case (act)
      nfa_pkg::ACT_ADD: ans.stat = add_heap(a, s);
      nfa_pkg::ACT_ALLOC: begin
        ok = 1'b0;
        start = (heap_cur < heap_cnt) ? heap_cur : 0;
        for (int v = 0; v < heap_cnt && !ok; v++) begin
          r = start + v;
          if (r >= heap_cnt) r -= heap_cnt;
          if (carve(r, s, ans.addr)) begin
            heap_cur = r;
            ok = 1'b1;
          end
        end
        if (!ok) begin
          ans.addr = '0;
          ans.stat = nfa_pkg::ST_NOFIT;
        end
      end
      nfa_pkg::ACT_FREE: ans.stat = give_back(a, s);
      default: ;
    endcase
    return ans;
  endfunction

  word_t plan[$];

  function automatic word_t row(logic [1:0] act, nfa_pkg::addr_t a, nfa_pkg::addr_t s,
                                bit typed = 0, nfa_pkg::addr_t ea = '0,
                                nfa_pkg::stat_t es = nfa_pkg::ST_OK);
    word_t w;
    w.action = act; w.addr = a; w.size = s;
    w.typed = typed; w.exp_addr = ea; w.exp_stat = es;
    return w;
  endfunction

  function automatic word_t random_word();
    int pick;
    int k;
    word_t w;
    pick = $urandom_range(0, 99);
    w = row(nfa_pkg::ACT_ALLOC, $urandom, $urandom_range(1, 96));
    if (pick < 40) begin
      if ($urandom_range(0, 9) == 0) w.size = $urandom_range(0, 1);
    end else if (pick < 75 && live.size() > 0) begin
      k = $urandom_range(0, live.size() - 1);
      w = row(nfa_pkg::ACT_FREE, live[k].addr, live[k].size);
      live.delete(k);
    end else if (pick < 85) begin
      w = row(nfa_pkg::ACT_FREE, $urandom,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64));
    end else if (pick < 92) begin
      w.size = $urandom;
    end else if (pick < 96) begin
      w = row(nfa_pkg::ACT_ADD, $urandom, $urandom);
    end else begin
      w = row(ACT_NONE, $urandom, $urandom);
    end
    return w;
  endfunction

  task automatic send_word(word_t w, bit burst);
    answer_t ans;
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= w.action;
    in_ch.addr   <= w.addr;
    in_ch.size   <= w.size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ans = allocator_step(w.action, w.addr, w.size);
    if (w.action == nfa_pkg::ACT_ALLOC && ans.stat == nfa_pkg::ST_OK && w.size != 0)
      live.push_back('{ans.addr, w.size});
    if (w.typed) begin
      ans.addr = w.exp_addr;
      ans.stat = w.exp_stat;
    end
    pending.push_back(ans);
  endtask

  // result side: random stalls, compare each word against the oldest expectation
  initial begin
    int stall;
    answer_t e;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 7) < 2) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending.size() == 0) begin
        $error("unexpected result word: result_addr %h status %0d",
               out_ch.result_addr, out_ch.status);
        errs++;
      end else begin
        e = pending.pop_front();
        if (out_ch.result_addr !== e.addr) begin
          $error("result_addr: expected %h, actual %h", e.addr, out_ch.result_addr);
          errs++;
        end
        if (out_ch.status !== e.stat) begin
          $error("status: expected %0d, actual %0d", e.stat, out_ch.status);
          errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle <= 0;
    end else if (idle >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle <= idle + 1;
    end
  end

  initial begin
    bit burst;
    errs = 0;
    idle = 0;
    heap_cnt = 0;
    heap_cur = 0;
    for (int r = 0; r < nfa_pkg::MAX_REGIONS; r++) begin
      blk_cnt[r] = 0;
      blk_cur[r] = 0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = nfa_pkg::ACT_ADD;
    in_ch.addr = '0;
    in_ch.size = '0;

    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h10, 1, 32'h0, nfa_pkg::ST_NOFIT));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'h4000, 32'h10, 1, 32'h0, nfa_pkg::ST_BELOW));
    plan.push_back(row(ACT_NONE, 32'h0, 32'h0, 1, 32'h0, nfa_pkg::ST_OK));
    plan.push_back(row(nfa_pkg::ACT_ADD, 32'h1000_0000, 32'h1000, 1, 32'h0, nfa_pkg::ST_OK));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'h0, 32'h4, 1, 32'h0, nfa_pkg::ST_BELOW));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h0, 1, 32'h1000_0000, nfa_pkg::ST_OK));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h10, 1, 32'h1000_0000, nfa_pkg::ST_OK));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'hFF0, 1, 32'h1000_0010, nfa_pkg::ST_OK));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h1, 1, 32'h0, nfa_pkg::ST_NOFIT));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'h1000_0000, 32'h10));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'h1000_0020, 32'h0));
    plan.push_back(row(nfa_pkg::ACT_ADD, 32'hFFFF_F000, 32'h1000));
    plan.push_back(row(nfa_pkg::ACT_ADD, 32'h1000_0000, 32'h100));
    plan.push_back(row(nfa_pkg::ACT_ADD, 32'h0, 32'hFFFF_FFFF));
    plan.push_back(row(nfa_pkg::ACT_ADD, 32'h8000_0000, 32'h10, 1, 32'h0, nfa_pkg::ST_FULL));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h0));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'hFFFF_FFF0, 32'h10));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'h1000_0010, 32'hFF0));
    plan.push_back(row(nfa_pkg::ACT_FREE, 32'h0, 32'hFFFF_FFFF));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h20));
    plan.push_back(row(nfa_pkg::ACT_ALLOC, 32'h0, 32'h0));
    plan.push_back(row(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, nfa_pkg::ST_OK));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i], 1'b0);
    burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      send_word(random_word(), burst);
    end
    in_ch.valid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
